/* rtl/crbpm_pkg.sv */
package crbpm_pkg;

    // ring geometry
    localparam int DATA_SIZE  = 4096;
    localparam int EXTRA_SIZE = 1024;

    // offset and size fields
    localparam int OFS_W   = 13;
    localparam int SIZE_W  = 13;
    localparam int SUM_W   = OFS_W + 1;
    localparam int USED_W  = OFS_W + 2;
    localparam int OFS_MAX = (1 << OFS_W) - 1;

    // remaining-space width allows for DATA_SIZE plus a full offset range
    localparam int REM_W = $clog2(DATA_SIZE + OFS_MAX + 1) + 1;

    // tail value after reset or after a read wrap
    localparam int TAIL_RST_I = (DATA_SIZE > OFS_MAX) ? OFS_MAX : DATA_SIZE;
    localparam logic [OFS_W-1:0] TAIL_RST = OFS_W'(TAIL_RST_I);

    // stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    typedef enum logic [1:0] {
        REQ_RSV_RD = 2'd0,
        REQ_REL_RD = 2'd1,
        REQ_RSV_WR = 2'd2,
        REQ_REL_WR = 2'd3
    } req_type_t;

endpackage

/* rtl/contiguous_ring_buffer_pointer_manager.sv */
// path: an accepted request beat passes the request register, then the result register
// throughput: one request per cycle unless m_tready stalls the result register, set by the
// single pointer update path between the request register and the result register
// reset: synchronous active-low aresetn clears read and write offsets, loads the
// tail with DATA_SIZE (saturated) and empties both pipeline registers
module contiguous_ring_buffer_pointer_manager (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [12:0] size, [15:13] zero
    input  logic [crbpm_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [crbpm_pkg::S_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [12:0] offset, [25:13] used_size, [38:26] remain_size, [39] zero
    output logic [crbpm_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] granted
    output logic [crbpm_pkg::M_USER_W-1:0]   m_tuser
);
    import crbpm_pkg::*;

    // request register
    logic              in_valid_reg;
    req_type_t         in_kind_reg;
    logic [SIZE_W-1:0] in_size_reg;

    // result register
    logic              out_valid_reg;
    logic              out_grant_reg;
    logic [OFS_W-1:0]  out_ofs_reg;
    logic [OFS_W-1:0]  out_used_reg;
    logic [OFS_W-1:0]  out_rem_reg;

    // pointer state
    logic [OFS_W-1:0]  rd_reg, rd_next;
    logic [OFS_W-1:0]  wr_reg, wr_next;
    logic [OFS_W-1:0]  tail_reg, tail_next;

    logic              advance;
    logic              step;

    logic signed [USED_W-1:0] used_diff;
    logic signed [USED_W-1:0] used_fix;
    logic [OFS_W-1:0]         used_val;
    logic signed [REM_W-1:0]  rem_diff;
    logic signed [REM_W-1:0]  rem_fix;
    logic [REM_W-2:0]         rem_val;
    logic [SUM_W-1:0]         rd_sum;
    logic [SUM_W-1:0]         wr_sum;
    logic                     grant;
    logic [OFS_W-1:0]         ofs;

    // handshake: result register moves when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // used size: write minus read, tail-corrected, clamped at zero
    always_comb begin
        used_diff = $signed({2'b00, wr_reg}) - $signed({2'b00, rd_reg});
        used_fix  = used_diff;
        if (used_diff < 0) begin
            used_fix = used_diff + $signed({2'b00, tail_reg});
        end
        used_val = (used_fix < 0) ? '0 : used_fix[OFS_W-1:0];
    end

    // remaining space: read minus write, plus DATA_SIZE if not positive
    always_comb begin
        rem_diff = $signed({{(REM_W-OFS_W){1'b0}}, rd_reg})
                 - $signed({{(REM_W-OFS_W){1'b0}}, wr_reg});
        rem_fix  = rem_diff;
        if (rem_diff <= 0) begin
            rem_fix = rem_diff + $signed(REM_W'(DATA_SIZE));
        end
        rem_val = (rem_fix < 0) ? '0 : rem_fix[REM_W-2:0];
    end

    assign rd_sum = {1'b0, rd_reg} + {1'b0, in_size_reg};
    assign wr_sum = {1'b0, wr_reg} + {1'b0, in_size_reg};

    // request decode and pointer update
    always_comb begin
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        tail_next = tail_reg;
        grant     = 1'b0;
        ofs       = '0;
        case (in_kind_reg)
            REQ_RSV_RD: begin
                if ({2'b00, in_size_reg} <= {2'b00, used_val}) begin
                    grant = 1'b1;
                    ofs   = rd_reg;
                end
            end
            REQ_REL_RD: begin
                if (32'(rd_sum) >= DATA_SIZE) begin
                    tail_next = TAIL_RST;
                    rd_next   = '0;
                end else begin
                    rd_next = rd_sum[SUM_W-1] ? OFS_W'(OFS_MAX) : rd_sum[OFS_W-1:0];
                end
                grant = 1'b1;
                ofs   = rd_next;
            end
            REQ_RSV_WR: begin
                if ((REM_W-1)'(in_size_reg) < rem_val) begin
                    grant = 1'b1;
                    ofs   = wr_reg;
                end
            end
            REQ_REL_WR: begin
                if (32'(wr_sum) >= DATA_SIZE) begin
                    tail_next = wr_sum[SUM_W-1] ? OFS_W'(OFS_MAX) : wr_sum[OFS_W-1:0];
                    wr_next   = '0;
                end else begin
                    wr_next = wr_sum[SUM_W-1] ? OFS_W'(OFS_MAX) : wr_sum[OFS_W-1:0];
                end
                grant = 1'b1;
                ofs   = wr_next;
            end
            default: begin
                grant = 1'b0;
            end
        endcase
    end

    // control and pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            tail_reg      <= TAIL_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step) begin
                rd_reg   <= rd_next;
                wr_reg   <= wr_next;
                tail_reg <= tail_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= req_type_t'(s_tuser[1:0]);
            in_size_reg <= s_tdata[SIZE_W-1:0];
        end
        if (step) begin
            out_grant_reg <= grant;
            out_ofs_reg   <= ofs;
            out_used_reg  <= used_val;
            out_rem_reg   <= rem_val[OFS_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_grant_reg;
    assign m_tdata  = {1'b0, out_rem_reg, out_used_reg, out_ofs_reg};

`ifndef SYNTHESIS
    // a refused reservation carries a zero offset
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_grant_reg |-> out_ofs_reg == '0)
        else $error("refused reservation with nonzero offset");

    // pointers only move when a request passes to the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(rd_reg) && $stable(wr_reg) && $stable(tail_reg))
        else $error("pointer state changed without a request");

    // write offset stays inside the ring or at saturation
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (32'(wr_reg) < DATA_SIZE) || (32'(wr_reg) == OFS_MAX))
        else $error("write offset out of range");
`endif

endmodule
